// ===== sv/met_pkg.sv =====
// Shared types, codes and sizes of the multi-slot event timer.
`default_nettype none

package met_pkg;

  // Default number of timer slots
  localparam int SLOTS_DEFAULT = 8;

  // Field widths
  localparam int EV_W  = 16;
  localparam int OWN_W = 4;
  localparam int CNT_W = 24;
  localparam int PER_W = 16;

  // Counter ceiling
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Input kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_UNSET = 2'd2;

  // Result kinds
  localparam logic [2:0] RK_FIRED      = 3'd0;
  localparam logic [2:0] RK_NONE       = 3'd1;
  localparam logic [2:0] RK_SET_DONE   = 3'd2;
  localparam logic [2:0] RK_FULL       = 3'd3;
  localparam logic [2:0] RK_UNSET_DONE = 3'd4;
  localparam logic [2:0] RK_NOT_FOUND  = 3'd5;

  // Input word
  typedef struct packed {
    logic [1:0]       kind;
    logic [EV_W-1:0]  event_id;
    logic [OWN_W-1:0] owner;
    logic [CNT_W-1:0] duration_ms;
    logic             periodic;
  } in_t;

  // Result word
  typedef struct packed {
    logic [2:0]       result_kind;
    logic [EV_W-1:0]  fired_event_id;
    logic [OWN_W-1:0] fired_owner;
    logic             last;
  } out_t;

  // One slot entry as held in the slot memory
  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [OWN_W-1:0] own;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count;
    logic             repeat_en;
    logic             done;
  } slot_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap;
    logic rd;
    logic div_start;
    logic tick_wr;
    logic tick_end;
    logic set_wr;
    logic set_full;
    logic unset_clr;
    logic unset_nf;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cur_valid;
    logic fire;
    logic match;
    logic out_free;
    logic pend_v;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/multi_slot_event_timer.sv =====
// A set word runs a 24-step divide, then a one-slot-per-cycle free search; a tick or
//   unset word walks the slots, reading each valid one from the slot memory.
// One word at a time: the input stays closed while the slot walk through the slot
//   memory and the divider run for the word taken.
// Reset: valid bits cleared, tick period 1, no memory clearing pass; the result
//   register lets the next word be taken while a result waits.
`default_nettype none

module multi_slot_event_timer import met_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire in_t              in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      out_t             out_data_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [PER_W-1:0] cfg_data_i
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] idx;

  // Period register always takes a write
  assign cfg_ready_o = 1'b1;

  met_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_kind_i  (in_data_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  met_dpath #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/met_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module met_ram #(
  parameter int W  = 8,
  parameter int D  = 8,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/met_div.sv =====
// Restoring divider, one quotient bit per cycle, for duration to tick limit.
`default_nettype none

module met_div import met_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CNT_W-1:0] dividend_i,
  input  wire logic [PER_W-1:0] divisor_i,
  output      logic             busy_o,
  output      logic [CNT_W-1:0] quot_o
);

  localparam int CW = $clog2(CNT_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PER_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] quo_q, quo_d;
  logic [PER_W-1:0] dvs_q, dvs_d;
  logic [PER_W:0]   trial;
  logic [PER_W:0]   diff;

  // One shift-subtract step; a zero divisor yields all ones
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[CNT_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(CNT_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[PER_W-1:0];
        quo_d = {quo_q[CNT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[PER_W-1:0];
        quo_d = {quo_q[CNT_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/met_dpath.sv =====
// Slot datapath: slot memory, valid bits, divider, pending fire and result register.
`default_nettype none

module met_dpath import met_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [IW-1:0]    idx_i,
  output      sts_t             sts_o,
  input  wire in_t              in_data_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [PER_W-1:0] cfg_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      out_t             out_data_o
);

  logic [PER_W-1:0] period_q;
  in_t              item_q;
  logic [SLOTS-1:0] valid_q;
  logic             pend_v_q;
  logic [EV_W-1:0]  pend_ev_q;
  logic [OWN_W-1:0] pend_own_q;
  logic             out_v_q;
  out_t             out_q;

  slot_t            rd_slot;
  slot_t            tick_slot;
  slot_t            set_slot;
  logic             fire;
  logic             div_busy;
  logic [CNT_W-1:0] quot;
  logic             push;
  out_t             res;

  // Duration divider
  met_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (in_data_i.duration_ms),
    .divisor_i  (period_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Slot memory
  met_ram #(
    .W (($bits(slot_t))),
    .D (SLOTS),
    .AW(IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tick_wr | cmd_i.set_wr),
    .waddr_i (idx_i),
    .wdata_i (cmd_i.set_wr ? set_slot : tick_slot),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_i),
    .rdata_o (rd_slot)
  );

  assign fire = (rd_slot.count >= rd_slot.limit) && !rd_slot.done;

  // Tick update of the slot just read
  always_comb begin
    tick_slot = rd_slot;
    if (fire) begin
      tick_slot.count = CNT_W'(1);
      tick_slot.done  = !rd_slot.repeat_en;
    end else if (rd_slot.count != CNT_MAX) begin
      tick_slot.count = rd_slot.count + CNT_W'(1);
    end
  end

  // Fresh entry for a set word
  always_comb begin
    set_slot.ev        = item_q.event_id;
    set_slot.own       = item_q.owner;
    set_slot.limit     = quot;
    set_slot.count     = '0;
    set_slot.repeat_en = item_q.periodic;
    set_slot.done      = 1'b0;
  end

  // Result selection
  always_comb begin
    push = 1'b0;
    res  = '0;
    if (cmd_i.tick_wr && fire && pend_v_q) begin
      push               = 1'b1;
      res.result_kind    = RK_FIRED;
      res.fired_event_id = pend_ev_q;
      res.fired_owner    = pend_own_q;
    end else if (cmd_i.tick_end) begin
      push     = 1'b1;
      res.last = 1'b1;
      if (pend_v_q) begin
        res.result_kind    = RK_FIRED;
        res.fired_event_id = pend_ev_q;
        res.fired_owner    = pend_own_q;
      end else begin
        res.result_kind = RK_NONE;
      end
    end else if (cmd_i.set_wr) begin
      push            = 1'b1;
      res.result_kind = RK_SET_DONE;
      res.last        = 1'b1;
    end else if (cmd_i.set_full) begin
      push            = 1'b1;
      res.result_kind = RK_FULL;
      res.last        = 1'b1;
    end else if (cmd_i.unset_clr) begin
      push            = 1'b1;
      res.result_kind = RK_UNSET_DONE;
      res.last        = 1'b1;
    end else if (cmd_i.unset_nf) begin
      push            = 1'b1;
      res.result_kind = RK_NOT_FOUND;
      res.last        = 1'b1;
    end
  end

  // Control state: period, valid bits, pending and output flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PER_W'(1);
      valid_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
      if (cmd_i.set_wr) begin
        valid_q[idx_i] <= 1'b1;
      end else if (cmd_i.unset_clr) begin
        valid_q[idx_i] <= 1'b0;
      end
      if (cmd_i.tick_wr && fire) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.tick_end) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      item_q <= in_data_i;
    end
    if (cmd_i.tick_wr && fire) begin
      pend_ev_q  <= rd_slot.ev;
      pend_own_q <= rd_slot.own;
    end
    if (push) begin
      out_q <= res;
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.cur_valid = valid_q[idx_i];
    sts_o.fire      = fire;
    sts_o.match     = (rd_slot.ev == item_q.event_id);
    sts_o.out_free  = !out_v_q || out_ready_i;
    sts_o.pend_v    = pend_v_q;
    sts_o.div_busy  = div_busy;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/met_ctrl.sv =====
// Controller: sequences divide, slot walks and result pushes for each input word.
`default_nettype none

module met_ctrl import met_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [1:0]    in_kind_i,
  input  wire sts_t          sts_i,
  output      cmd_t          cmd_o,
  output      logic [IW-1:0] idx_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_TRD,
    S_TEV,
    S_TEND,
    S_URD,
    S_UEV,
    S_UNF
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          is_last;

  assign is_last = (idx_q == IW'(SLOTS - 1));

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          idx_d     = '0;
          unique case (in_kind_i)
            KIND_TICK:  state_d = S_TRD;
            KIND_SET: begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
            KIND_UNSET: state_d = S_URD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_SCAN;
        end
      end
      // Look for the first free slot
      S_SCAN: begin
        if (!sts_i.cur_valid) begin
          if (sts_i.out_free) begin
            cmd_o.set_wr = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (is_last) begin
          if (sts_i.out_free) begin
            cmd_o.set_full = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      // Tick walk: read a valid slot, then update it
      S_TRD: begin
        if (sts_i.cur_valid) begin
          cmd_o.rd = 1'b1;
          state_d  = S_TEV;
        end else if (is_last) begin
          state_d = S_TEND;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_TEV: begin
        if (!(sts_i.fire && sts_i.pend_v && !sts_i.out_free)) begin
          cmd_o.tick_wr = 1'b1;
          if (is_last) begin
            state_d = S_TEND;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_TRD;
          end
        end
      end
      S_TEND: begin
        if (sts_i.out_free) begin
          cmd_o.tick_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      // Unset walk: read a valid slot, then compare its id
      S_URD: begin
        if (sts_i.cur_valid) begin
          cmd_o.rd = 1'b1;
          state_d  = S_UEV;
        end else if (is_last) begin
          state_d = S_UNF;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_UEV: begin
        if (sts_i.match) begin
          if (sts_i.out_free) begin
            cmd_o.unset_clr = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (is_last) begin
          state_d = S_UNF;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_URD;
        end
      end
      S_UNF: begin
        if (sts_i.out_free) begin
          cmd_o.unset_nf = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

`default_nettype wire

// ===== sv/met_checker.sv =====
// Port-level checks for the event timer and their binding to the top level.
`default_nettype none

module met_checker import met_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire in_t              in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire out_t             out_data_o,
  input wire logic             cfg_valid_i,
  input wire logic             cfg_ready_o,
  input wire logic [PER_W-1:0] cfg_data_i
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Only fire results carry an id or owner
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind != RK_FIRED) |->
      (out_data_o.fired_event_id == '0) && (out_data_o.fired_owner == '0))
    else $error("non-fire result with nonzero id or owner");

  // Every non-fire result ends its word's results
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind != RK_FIRED) |-> out_data_o.last)
    else $error("non-fire result without last");

  // Result codes stay in range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_kind <= RK_NOT_FOUND))
    else $error("result kind out of range");

  // A tick, set or unset word keeps the input closed the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
      (in_data_i.kind == KIND_TICK || in_data_i.kind == KIND_SET ||
       in_data_i.kind == KIND_UNSET) |=> !in_ready_o)
    else $error("input taken again before word finished");

endmodule

bind multi_slot_event_timer met_checker u_met_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire
